[rtl/breakpoint_watchpoint_unit_defines.svh]
// ----------------------------------------------------------------------------
// Breakpoint/watchpoint unit assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_WATCHPOINT_UNIT_DEFINES_SVH
`define BREAKPOINT_WATCHPOINT_UNIT_DEFINES_SVH

// same-cycle implication
`define BWU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwu: same-cycle check failed");

// next-cycle implication
`define BWU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwu: next-cycle check failed");

`endif

[rtl/bwu_pkg.sv]
// ----------------------------------------------------------------------------
// bwu_pkg
// Types and codes of the breakpoint/watchpoint unit.
// ----------------------------------------------------------------------------
package bwu_pkg;

    localparam logic [2:0] REQ_CHECK   = 3'd0;
    localparam logic [2:0] REQ_ADD_BRK = 3'd1;
    localparam logic [2:0] REQ_REM_BRK = 3'd2;
    localparam logic [2:0] REQ_ADD_WCH = 3'd3;
    localparam logic [2:0] REQ_REM_WCH = 3'd4;
    localparam logic [2:0] REQ_RESUME  = 3'd5;
    localparam logic [2:0] REQ_STEP    = 3'd6;

    localparam logic [1:0] STORE_NONE = 2'd0;
    localparam logic [1:0] STORE_BYTE = 2'd1;
    localparam logic [1:0] STORE_WORD = 2'd2;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WATCH = 2'd1;
    localparam logic [1:0] ACT_BREAK = 2'd2;
    localparam logic [1:0] ACT_IDLE  = 2'd3;

    localparam logic [15:0] BREAK_RESET_ADDR = 16'h0000;

    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_STORE = 2'd1,
        HIT_INSTR = 2'd2
    } t_hit_sel;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] address;
        logic [1:0]  store_kind;
        logic [15:0] store_address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] hit_address;
        logic        table_full;
        logic        is_running;
    } t_out_word;

    typedef struct packed {
        logic       load_req;
        logic       sel_load;
        logic       sel_watch;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_last;
        logic       move_wr;
        logic       add_wr;
        logic       set_res;
        logic [1:0] res_action;
        t_hit_sel   res_hit;
        logic       run_set;
        logic       run_clr;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] store_kind;
        logic       run;
        logic       brk_empty;
        logic       wch_empty;
        logic       sel_watch;
        logic       match;
        logic       idx_last;
    } t_status;

endpackage

[rtl/bwu_ram.sv]
// ----------------------------------------------------------------------------
// bwu_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bwu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bwu_ctrl.sv]
// ----------------------------------------------------------------------------
// bwu_ctrl
// Request sequencer: decodes a word, steps table scans, delivers the result.
// ----------------------------------------------------------------------------
module bwu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bwu_pkg::t_status i_status,
    output bwu_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_RD     = 6'b000100,
        S_CMP    = 6'b001000,
        S_MOVE   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_out_valid;
    logic          n_out_valid;
    bwu_pkg::t_cmd cmd;
    logic          is_store;

    assign is_store = (i_status.store_kind == bwu_pkg::STORE_BYTE) ||
                      (i_status.store_kind == bwu_pkg::STORE_WORD);

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.res_action = bwu_pkg::ACT_IDLE;
        cmd.res_hit    = bwu_pkg::HIT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_status.req_type) inside
                    bwu_pkg::REQ_CHECK: begin
                        if (!i_status.run) begin
                            cmd.set_res = 1'b1;
                        end else if (is_store && !i_status.wch_empty) begin
                            cmd.sel_load  = 1'b1;
                            cmd.sel_watch = 1'b1;
                            cmd.idx_clr   = 1'b1;
                            n_state       = S_RD;
                        end else if (!i_status.brk_empty) begin
                            cmd.sel_load = 1'b1;
                            cmd.idx_clr  = 1'b1;
                            n_state      = S_RD;
                        end else begin
                            cmd.set_res    = 1'b1;
                            cmd.res_action = bwu_pkg::ACT_EXEC;
                        end
                    end
                    bwu_pkg::REQ_ADD_BRK, bwu_pkg::REQ_ADD_WCH: begin
                        cmd.add_wr  = 1'b1;
                        cmd.set_res = 1'b1;
                    end
                    bwu_pkg::REQ_REM_BRK: begin
                        if (i_status.brk_empty) begin
                            cmd.set_res = 1'b1;
                        end else begin
                            cmd.sel_load = 1'b1;
                            cmd.idx_clr  = 1'b1;
                            n_state      = S_RD;
                        end
                    end
                    bwu_pkg::REQ_REM_WCH: begin
                        if (i_status.wch_empty) begin
                            cmd.set_res = 1'b1;
                        end else begin
                            cmd.sel_load  = 1'b1;
                            cmd.sel_watch = 1'b1;
                            cmd.idx_clr   = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                    bwu_pkg::REQ_RESUME: begin
                        cmd.run_set    = 1'b1;
                        cmd.set_res    = 1'b1;
                        cmd.res_action = bwu_pkg::ACT_EXEC;
                    end
                    bwu_pkg::REQ_STEP: begin
                        cmd.set_res    = 1'b1;
                        cmd.res_action = bwu_pkg::ACT_EXEC;
                    end
                    default: begin
                        cmd.set_res = 1'b1;
                    end
                endcase
            end
            S_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                n_state = S_DONE;
                if (i_status.match) begin
                    if (i_status.req_type == bwu_pkg::REQ_CHECK) begin
                        cmd.run_clr = 1'b1;
                        cmd.set_res = 1'b1;
                        if (i_status.sel_watch) begin
                            cmd.res_action = bwu_pkg::ACT_WATCH;
                            cmd.res_hit    = bwu_pkg::HIT_STORE;
                        end else begin
                            cmd.res_action = bwu_pkg::ACT_BREAK;
                            cmd.res_hit    = bwu_pkg::HIT_INSTR;
                        end
                    end else begin
                        cmd.rd_last = 1'b1;
                        n_state     = S_MOVE;
                    end
                end else if (!i_status.idx_last) begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_RD;
                end else if (i_status.req_type == bwu_pkg::REQ_CHECK) begin
                    if (i_status.sel_watch && !i_status.brk_empty) begin
                        cmd.sel_load = 1'b1;
                        cmd.idx_clr  = 1'b1;
                        n_state      = S_RD;
                    end else begin
                        cmd.set_res    = 1'b1;
                        cmd.res_action = bwu_pkg::ACT_EXEC;
                    end
                end else begin
                    cmd.set_res = 1'b1;
                end
            end
            S_MOVE: begin
                cmd.move_wr = 1'b1;
                cmd.set_res = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[rtl/bwu_dp.sv]
// ----------------------------------------------------------------------------
// bwu_dp
// Datapath: request latch, both address tables, counts, run flag, result.
// ----------------------------------------------------------------------------
module bwu_dp #(
    parameter int BREAK_ENTRIES = 16,
    parameter int WATCH_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bwu_pkg::t_in_word  i_in_word,
    input  bwu_pkg::t_cmd      i_cmd,
    output bwu_pkg::t_status   o_status,
    output bwu_pkg::t_out_word o_out_word
);

    localparam int BIW = (BREAK_ENTRIES > 1) ? $clog2(BREAK_ENTRIES) : 1;
    localparam int WIW = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;
    localparam int XIW = (BIW > WIW) ? BIW : WIW;
    localparam int BCW = $clog2(BREAK_ENTRIES + 1);
    localparam int WCW = $clog2(WATCH_ENTRIES + 1);

    bwu_pkg::t_in_word r_req;
    logic [BCW-1:0]    r_bcnt;
    logic [WCW-1:0]    r_wcnt;
    logic              r_run;
    logic              r_sel_watch;
    logic [XIW-1:0]    r_idx;
    logic [XIW-1:0]    r_slot;
    logic              r_rd_zero;
    logic              r_b0_wr;
    logic [1:0]        r_act;
    logic [15:0]       r_hit;
    logic              r_full;
    bwu_pkg::t_out_word r_out;

    logic              brk_full;
    logic              wch_full;
    logic              sel_full;
    logic [BCW-1:0]    bcnt_dec;
    logic [WCW-1:0]    wcnt_dec;
    logic [BIW-1:0]    b_raddr;
    logic [WIW-1:0]    w_raddr;
    logic              b_re;
    logic              w_re;
    logic              b_we;
    logic              w_we;
    logic [BIW-1:0]    b_waddr;
    logic [WIW-1:0]    w_waddr;
    logic [15:0]       b_wdata;
    logic [15:0]       w_wdata;
    logic [15:0]       b_rdata;
    logic [15:0]       w_rdata;
    logic [15:0]       b_data;
    logic [15:0]       sel_data;
    logic [15:0]       saddr_nxt;
    logic              brk_add;
    logic              wch_add;
    logic              idx_last_b;
    logic              idx_last_w;
    logic              match;

    assign brk_full = (r_bcnt == BCW'(BREAK_ENTRIES));
    assign wch_full = (r_wcnt == WCW'(WATCH_ENTRIES));
    assign bcnt_dec = r_bcnt - BCW'(1);
    assign wcnt_dec = r_wcnt - WCW'(1);

    assign brk_add = i_cmd.add_wr && (r_req.req_type == bwu_pkg::REQ_ADD_BRK) && !brk_full;
    assign wch_add = i_cmd.add_wr && (r_req.req_type == bwu_pkg::REQ_ADD_WCH) && !wch_full;

    assign sel_full = ((r_req.req_type == bwu_pkg::REQ_ADD_BRK) && brk_full) ||
                      ((r_req.req_type == bwu_pkg::REQ_ADD_WCH) && wch_full);

    // read address: scan index, or last live entry for a remove
    assign b_raddr = i_cmd.rd_last ? bcnt_dec[BIW-1:0] : r_idx[BIW-1:0];
    assign w_raddr = i_cmd.rd_last ? wcnt_dec[WIW-1:0] : r_idx[WIW-1:0];
    assign b_re    = (i_cmd.rd_en || i_cmd.rd_last) && !r_sel_watch;
    assign w_re    = (i_cmd.rd_en || i_cmd.rd_last) && r_sel_watch;

    assign b_we    = brk_add || (i_cmd.move_wr && !r_sel_watch);
    assign w_we    = wch_add || (i_cmd.move_wr && r_sel_watch);
    assign b_waddr = i_cmd.move_wr ? r_slot[BIW-1:0] : r_bcnt[BIW-1:0];
    assign w_waddr = i_cmd.move_wr ? r_slot[WIW-1:0] : r_wcnt[WIW-1:0];
    assign b_wdata = i_cmd.move_wr ? b_data : r_req.address;
    assign w_wdata = i_cmd.move_wr ? w_rdata : r_req.address;

    // entry zero of the break table reads as its reset address until written
    assign b_data   = (r_rd_zero && !r_b0_wr) ? bwu_pkg::BREAK_RESET_ADDR : b_rdata;
    assign sel_data = r_sel_watch ? w_rdata : b_data;

    assign saddr_nxt = 16'(r_req.store_address + 16'd1);

    always_comb begin
        if (r_sel_watch && (r_req.req_type == bwu_pkg::REQ_CHECK)) begin
            match = (sel_data == r_req.store_address) ||
                    ((r_req.store_kind == bwu_pkg::STORE_WORD) && (sel_data == saddr_nxt));
        end else begin
            match = (sel_data == r_req.address);
        end
    end

    assign idx_last_b = ((BCW'(r_idx[BIW-1:0]) + BCW'(1)) >= r_bcnt);
    assign idx_last_w = ((WCW'(r_idx[WIW-1:0]) + WCW'(1)) >= r_wcnt);

    bwu_ram #(
        .WIDTH (16),
        .DEPTH (BREAK_ENTRIES)
    ) u_brk_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    bwu_ram #(
        .WIDTH (16),
        .DEPTH (WATCH_ENTRIES)
    ) u_wch_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt  <= BCW'(1);
            r_wcnt  <= '0;
            r_run   <= 1'b0;
            r_b0_wr <= 1'b0;
        end else begin
            if (brk_add) begin
                r_bcnt <= r_bcnt + BCW'(1);
            end else if (i_cmd.move_wr && !r_sel_watch) begin
                r_bcnt <= bcnt_dec;
            end
            if (wch_add) begin
                r_wcnt <= r_wcnt + WCW'(1);
            end else if (i_cmd.move_wr && r_sel_watch) begin
                r_wcnt <= wcnt_dec;
            end
            if (i_cmd.run_set) begin
                r_run <= 1'b1;
            end else if (i_cmd.run_clr) begin
                r_run <= 1'b0;
            end
            if (b_we && (b_waddr == '0)) begin
                r_b0_wr <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_word;
        end
        if (i_cmd.sel_load) begin
            r_sel_watch <= i_cmd.sel_watch;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + XIW'(1);
        end
        if (i_cmd.rd_last) begin
            r_slot <= r_idx;
        end
        if (b_re) begin
            r_rd_zero <= (b_raddr == '0);
        end
        if (i_cmd.set_res) begin
            r_act  <= i_cmd.res_action;
            r_full <= sel_full;
            case (i_cmd.res_hit)
                bwu_pkg::HIT_STORE: r_hit <= r_req.store_address;
                bwu_pkg::HIT_INSTR: r_hit <= r_req.address;
                default:            r_hit <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.action      <= r_act;
            r_out.hit_address <= r_hit;
            r_out.table_full  <= r_full;
            r_out.is_running  <= r_run;
        end
    end

    assign o_status.req_type   = r_req.req_type;
    assign o_status.store_kind = r_req.store_kind;
    assign o_status.run        = r_run;
    assign o_status.brk_empty  = (r_bcnt == '0);
    assign o_status.wch_empty  = (r_wcnt == '0);
    assign o_status.sel_watch  = r_sel_watch;
    assign o_status.match      = match;
    assign o_status.idx_last   = r_sel_watch ? idx_last_w : idx_last_b;

    assign o_out_word = r_out;

endmodule

[rtl/breakpoint_watchpoint_unit.sv]
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_unit
// Debug breakpoint and watchpoint tables with run control.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_word) carries one request word:
// check an instruction, add or remove a break/watch address, resume or step.
// Output channel (o_out_valid / i_out_ready / o_out_word) returns one result
// word per request: action, hit address, table-full flag and run flag.
// One request is processed at a time. Add, resume, step, a check while halted
// and a remove from an empty table need no table scan; a check or remove scans
// table entries, and a successful remove then moves the last entry into the
// matched slot. The input is ready again from the edge that loads the result.
// Each scanned entry costs one RAM read and one compare; a store check walks the
// watch table first, then the break table.
// Reset: halted, break table holds one entry (address 0), watch table empty.
// A stalled result stays in the output register; the next request is
// accepted meanwhile and waits in its final step until the output is free.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_unit #(
    parameter int BREAK_ENTRIES = 16,
    parameter int WATCH_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bwu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bwu_pkg::t_out_word o_out_word
);

    bwu_pkg::t_cmd    cmd;
    bwu_pkg::t_status status;

    bwu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bwu_dp #(
        .BREAK_ENTRIES (BREAK_ENTRIES),
        .WATCH_ENTRIES (WATCH_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

endmodule

[rtl/bwu_checker.sv]
// ----------------------------------------------------------------------------
// bwu_checker
// Port-level checks for the breakpoint/watchpoint unit, bound to the top.
// ----------------------------------------------------------------------------
`include "breakpoint_watchpoint_unit_defines.svh"

module bwu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bwu_pkg::t_out_word o_out_word
);

    `BWU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))
    `BWU_ASSERT_NOW(a_hit_halts, i_clk, i_rst_n, o_out_valid && ((o_out_word.action == bwu_pkg::ACT_WATCH) || (o_out_word.action == bwu_pkg::ACT_BREAK)), !o_out_word.is_running)
    `BWU_ASSERT_NOW(a_full_idle, i_clk, i_rst_n, o_out_valid && o_out_word.table_full, (o_out_word.action == bwu_pkg::ACT_IDLE) && (o_out_word.hit_address == 16'h0000))
    `BWU_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind breakpoint_watchpoint_unit bwu_checker u_bwu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
